// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/aes_pkg.sv -----
package aes_pkg;

    localparam int NumRounds = 10;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd1: v = 8'h01;
            4'd2: v = 8'h02;
            4'd3: v = 8'h04;
            4'd4: v = 8'h08;
            4'd5: v = 8'h10;
            4'd6: v = 8'h20;
            4'd7: v = 8'h40;
            4'd8: v = 8'h80;
            4'd9: v = 8'h1B;
            4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] gdouble(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
    endfunction

endpackage

// ----- hw/rtl/aes_round_cell.sv -----
module aes_round_cell
    import aes_pkg::*;
(
    input  logic         aclk,
    input  logic         en,
    input  logic [3:0]   round,
    input  logic [127:0] state_in,
    input  logic [127:0] key_in,
    output logic [127:0] state_out,
    output logic [127:0] key_out
);

    // byte n at bits [127-8n -: 8]
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [7:0]   m [16];
    logic [7:0]   p [16];
    logic [7:0]   q [16];
    logic [127:0] state_next;
    logic [127:0] key_next;
    logic [127:0] state_reg;
    logic [127:0] key_reg;
    logic [7:0]   a0, a1, a2, a3, al;

    always_comb begin
        for (int n = 0; n < 16; n++) begin
            s[n] = state_in[127-8*n -: 8];
            p[n] = key_in[127-8*n -: 8];
        end
        q[0] = p[0] ^ sbox(p[13]) ^ rcon(round);
        q[1] = p[1] ^ sbox(p[14]);
        q[2] = p[2] ^ sbox(p[15]);
        q[3] = p[3] ^ sbox(p[12]);
        for (int n = 4; n < 16; n++) begin
            q[n] = p[n] ^ q[n-4];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*c+r] = sbox(s[4*((c+r)%4)+r]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (round == 4'(NumRounds)) begin
                m[4*c] = a0; m[4*c+1] = a1; m[4*c+2] = a2; m[4*c+3] = a3;
            end else begin
                m[4*c]   = a0 ^ al ^ gdouble(a0 ^ a1);
                m[4*c+1] = a1 ^ al ^ gdouble(a1 ^ a2);
                m[4*c+2] = a2 ^ al ^ gdouble(a2 ^ a3);
                m[4*c+3] = a3 ^ al ^ gdouble(a3 ^ a0);
            end
        end
        for (int n = 0; n < 16; n++) begin
            key_next[127-8*n -: 8]   = q[n];
            state_next[127-8*n -: 8] = m[n] ^ q[n];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign state_out = state_reg;
    assign key_out   = key_reg;

endmodule

// ----- hw/rtl/aes128_block_encrypt_core.sv -----
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | block_high, block_low, key_high, key_low (256 bits)
// m_axis  | out | cipher_high, cipher_low (128 bits)
// One AddRoundKey stage then ten round cells, one block per cycle while the output is not stalled.
// The whole chain advances when the last stage is empty or taken; a stall freezes it.
// aresetn clears only the stage valid bits.
module aes128_block_encrypt_core
    import aes_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [255:0] s_axis_tdata,  // block_high, block_low, key_high, key_low
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata   // cipher_high, cipher_low
);

    logic [NumRounds:0] vld_reg;
    logic [NumRounds:0] vld_next;
    logic               adv;
    logic [127:0]       st   [NumRounds+1];
    logic [127:0]       ky   [NumRounds+1];
    logic [127:0]       st0_reg;
    logic [127:0]       ky0_reg;
    logic [127:0]       blk;
    logic [127:0]       key;

    assign blk = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    assign key = {s_axis_tdata[191:128], s_axis_tdata[255:192]};
    assign adv = !vld_reg[NumRounds] || m_axis_tready;
    assign s_axis_tready = adv;

    always_comb begin
        vld_next = vld_reg;
        if (adv) begin
            vld_next = {vld_reg[NumRounds-1:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st0_reg <= blk ^ key;
            ky0_reg <= key;
        end
    end

    assign st[0] = st0_reg;
    assign ky[0] = ky0_reg;

    for (genvar g = 1; g <= NumRounds; g++) begin : g_cell
        aes_round_cell u_cell (
            .aclk      (aclk),
            .en        (adv),
            .round     (4'(g)),
            .state_in  (st[g-1]),
            .key_in    (ky[g-1]),
            .state_out (st[g]),
            .key_out   (ky[g])
        );
    end

    assign m_axis_tvalid = vld_reg[NumRounds];
    assign m_axis_tdata  = {st[NumRounds][63:0], st[NumRounds][127:64]};

endmodule

// ----- hw/rtl/aes_core_checker.sv -----
`include "assert_macros.svh"
module aes_core_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);
    `ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ASSERT_NEXT(a_hold_data, aclk, aresetn, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `ASSERT_IMPL(a_ready_free, aclk, aresetn, !m_axis_tvalid, s_axis_tready)
    `ASSERT_IMPL(a_ready_drain, aclk, aresetn, m_axis_tready, s_axis_tready)
endmodule

bind aes128_block_encrypt_core aes_core_checker u_chk (.*);
